// File: rtl/core/bpt_pkg.sv
// Package for the beacon peer table: sizes, beacon constants, result codes,
// sequencer types and width helpers.
// No dependencies.
package bpt_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int ID_W     = 16;
    localparam int SLOT_W   = 3;
    localparam int PCOUNT_W = 4;
    localparam int POS_W    = 32;
    // entry payload: lat, lon, alt, sats, last seen
    localparam int ENTRY_W  = POS_W + POS_W + 16 + 8 + 32;

    localparam logic [7:0] BEACON_MARK  = 8'hB7;
    localparam logic [7:0] BEACON_BYTES = 8'd14;

    typedef enum logic [2:0] {
        ST_UPDATED    = 3'd0,
        ST_INSERTED   = 3'd1,
        ST_FULL       = 3'd2,
        ST_READ_ERROR = 3'd3,
        ST_NOT_BEACON = 3'd4,
        ST_OWN_ECHO   = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_seq_state;

    // header fields the sequencer checks
    typedef struct packed {
        logic             ok;
        logic [7:0]       len;
        logic [7:0]       magic;
        logic [ID_W-1:0]  id;
    } t_chk;

    // result handed from the sequencer to the table
    typedef struct packed {
        logic             done;
        logic             wr;
        t_status          status;
        logic [IDX_W-1:0] slot;
    } t_seq_res;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [31:0] w;
        w = 32'(idx);
        return w[SLOT_W-1:0];
    endfunction

    function automatic logic [PCOUNT_W-1:0] to_pcount(input logic [CNT_W-1:0] cnt);
        logic [31:0] w;
        w = 32'(cnt);
        return w[PCOUNT_W-1:0];
    endfunction

endpackage

// File: rtl/core/beacon_peer_table.sv
// Beacon peer table. The result follows the header check for a rejected item or an
// empty table, else the scan of the stored ids up to a match; a busy output holds it.
// A new item is taken only when the sequencer is idle again; the id scan runs through
// the single comparator, one RAM entry per cycle.
// Reset (synchronous, active low) clears the peer count, own id and handshake
// state; table RAM contents are left as they are.
module beacon_peer_table
    import bpt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata,      // own_id
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // rx_length[7:0], magic[15:8], peer_id[31:16], latitude[59:32],
    // longitude[88:60], altitude[104:89], sat_count[112:105], now_ms[144:113]
    input  logic [151:0]  s_axis_tdata,
    input  logic          s_axis_tuser,     // rx_ok
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [7:0]    m_axis_tdata,     // slot[2:0], peer_count[6:3]
    output logic [2:0]    m_axis_tuser      // status
);

    logic [ID_W-1:0]  r_own_id;
    logic [CNT_W-1:0] r_count, n_count;

    logic             r_ok;
    logic [7:0]       r_len;
    logic [7:0]       r_magic;
    logic [ID_W-1:0]  r_peer_id;
    logic [27:0]      r_lat;
    logic [28:0]      r_lon;
    logic [15:0]      r_alt;
    logic [7:0]       r_sats;
    logic [31:0]      r_now;

    logic                r_out_valid;
    t_status             r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [PCOUNT_W-1:0] r_out_count;

    logic             in_accept;
    logic             out_free;
    logic             seq_idle;
    t_chk             chk;
    t_seq_res         res;
    logic [IDX_W-1:0] rd_addr;
    logic [ID_W-1:0]  rd_id;
    logic             tbl_we;
    logic [ENTRY_W-1:0] entry;

    assign s_axis_tready = seq_idle;
    assign in_accept     = s_axis_tvalid && seq_idle;
    assign out_free      = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ok      <= s_axis_tuser;
            r_len     <= s_axis_tdata[7:0];
            r_magic   <= s_axis_tdata[15:8];
            r_peer_id <= s_axis_tdata[31:16];
            r_lat     <= s_axis_tdata[59:32];
            r_lon     <= s_axis_tdata[88:60];
            r_alt     <= s_axis_tdata[104:89];
            r_sats    <= s_axis_tdata[112:105];
            r_now     <= s_axis_tdata[144:113];
        end
    end

    assign chk.ok    = r_ok;
    assign chk.len   = r_len;
    assign chk.magic = r_magic;
    assign chk.id    = r_peer_id;

    bpt_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_accept),
        .i_chk      (chk),
        .i_own_id   (r_own_id),
        .i_count    (r_count),
        .i_rd_id    (rd_id),
        .i_out_free (out_free),
        .o_rd_addr  (rd_addr),
        .o_idle     (seq_idle),
        .o_res      (res)
    );

    assign tbl_we = res.done && res.wr;
    // positions kept sign-extended to 32 bits
    assign entry  = {r_now, r_sats, r_alt, {3{r_lon[28]}}, r_lon, {4{r_lat[27]}}, r_lat};

    bpt_ram #(
        .WIDTH (ID_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_id_ram (
        .i_clk     (i_clk),
        .i_we      (tbl_we),
        .i_wr_addr (res.slot),
        .i_wr_data (r_peer_id),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_id)
    );

    bpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_we      (tbl_we),
        .i_wr_addr (res.slot),
        .i_wr_data (entry),
        .i_rd_addr (rd_addr),
        .o_rd_data ()
    );

    always_comb begin
        n_count = r_count;
        if (res.done && res.status == ST_INSERTED) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_own_id <= i_cfg_wdata;
            end
            r_count <= n_count;
            if (res.done) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res.done) begin
            r_out_status <= res.status;
            r_out_slot   <= to_slot(res.slot);
            r_out_count  <= to_pcount(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {1'b0, r_out_count, r_out_slot};

    // the table never holds more peers than it has slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES))
        else $error("peer count beyond table size");

    // an accepted item leaves the sequencer busy, so ready drops after it
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !s_axis_tready)
        else $error("ready high right after an accepted item");

    // nothing stored means slot zero
    a_reject_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.done && !res.wr) |-> (res.slot == '0))
        else $error("non-zero slot on a result that stored nothing");

    // an insertion grows the count by exactly one
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.done && res.status == ST_INSERTED) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insertion did not bump the peer count");

endmodule

// File: rtl/core/bpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/bpt_seq.sv
// Sequencer with the shared id comparator: header checks, then a scan of
// the id RAM one entry a cycle. Depends on bpt_pkg.
module bpt_seq
    import bpt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_chk             i_chk,
    input  logic [ID_W-1:0]  i_own_id,
    input  logic [CNT_W-1:0] i_count,
    input  logic [ID_W-1:0]  i_rd_id,
    input  logic             i_out_free,
    output logic [IDX_W-1:0] o_rd_addr,
    output logic             o_idle,
    output t_seq_res         o_res
);

    t_seq_state       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_status          r_status, n_status;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic             r_wr, n_wr;

    logic [ID_W-1:0]  cmp_b;
    logic             id_eq;
    logic             last_entry;
    logic             table_full;

    // one comparator: own id during the check, stored ids during the scan
    assign cmp_b      = (r_state == S_CHECK) ? i_own_id : i_rd_id;
    assign id_eq      = (i_chk.id == cmp_b);
    assign last_entry = ((CNT_W'(r_idx) + 1'b1) == i_count);
    assign table_full = (i_count == CNT_W'(TABLE_ENTRIES));

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_status = r_status;
        n_slot   = r_slot;
        n_wr     = r_wr;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CHECK;
                    n_idx   = '0;
                end
            end
            S_CHECK: begin
                n_slot  = '0;
                n_wr    = 1'b0;
                n_state = S_DONE;
                n_idx   = '0;
                if (!i_chk.ok) begin
                    n_status = ST_READ_ERROR;
                end else if (i_chk.len < BEACON_BYTES || i_chk.magic != BEACON_MARK) begin
                    n_status = ST_NOT_BEACON;
                end else if (id_eq) begin
                    n_status = ST_OWN_ECHO;
                end else if (i_count == '0) begin
                    n_status = ST_INSERTED;
                    n_wr     = 1'b1;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (id_eq) begin
                    n_status = ST_UPDATED;
                    n_slot   = r_idx;
                    n_wr     = 1'b1;
                    n_state  = S_DONE;
                end else if (last_entry) begin
                    n_state = S_DONE;
                    if (table_full) begin
                        n_status = ST_FULL;
                        n_slot   = '0;
                        n_wr     = 1'b0;
                    end else begin
                        n_status = ST_INSERTED;
                        n_slot   = i_count[IDX_W-1:0];
                        n_wr     = 1'b1;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wr    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wr    <= n_wr;
        end
        r_idx    <= n_idx;
        r_status <= n_status;
        r_slot   <= n_slot;
    end

    // read data is registered in the RAM, so address the next index
    assign o_rd_addr    = n_idx;
    assign o_idle       = (r_state == S_IDLE);
    assign o_res.done   = (r_state == S_DONE) && i_out_free;
    assign o_res.wr     = r_wr;
    assign o_res.status = r_status;
    assign o_res.slot   = r_slot;

endmodule

// File: bench/tb_top.sv
// Self-checking bench for beacon_peer_table: drives decoded beacons over the
// input stream, predicts status, slot and peer count, and checks every result.
// Depends on bpt_pkg and the beacon_peer_table RTL.
`timescale 1ns / 1ps

module tb_top;
    import bpt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = TABLE_ENTRIES + 8;
    localparam int LONG_HOLD   = 300;

    // beacon body in the bit order of s_axis_tdata, lowest field last
    typedef struct packed {
        logic [31:0]        now_ms;
        logic [7:0]         sats;
        logic signed [15:0] alt;
        logic signed [28:0] lon;
        logic signed [27:0] lat;
        logic [15:0]        peer;
        logic [7:0]         magic;
        logic [7:0]         len;
    } beacon_t;

    typedef struct packed {
        logic    rx_ok;
        beacon_t body;
    } rx_item_t;

    typedef struct {
        t_status    status;
        logic [2:0] slot;
        logic [3:0] count;
    } reply_t;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         i_cfg_we      = 1'b0;
    logic [15:0]  i_cfg_wdata   = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata  = '0;
    logic         s_axis_tuser  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    beacon_peer_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // shadow of the peer table and the own id
    beacon_t     peers[TABLE_ENTRIES];
    int          peer_count = 0;
    logic [15:0] node_id    = '0;

    rx_item_t beacon_q[$];
    reply_t   reply_q[$];

    int  fault_count = 0;
    int  cycle_count = 0;
    bit  in_taken    = 1'b0;
    bit  calm        = 1'b0;
    bit  hold_arm    = 1'b0;
    bit  hold_spent  = 1'b0;
    int  tx_gap      = 0;
    int  rx_stall    = 0;
    int  hold_left   = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic reply_t predict_reply(input rx_item_t it);
        reply_t r;
        int     hit;
        hit     = -1;
        r.slot  = '0;
        if (!it.rx_ok) begin
            r.status = ST_READ_ERROR;
        end else if (it.body.len < BEACON_BYTES || it.body.magic != BEACON_MARK) begin
            r.status = ST_NOT_BEACON;
        end else if (it.body.peer == node_id) begin
            r.status = ST_OWN_ECHO;
        end else begin
            for (int i = 0; i < peer_count; i++) begin
                if (hit < 0 && peers[i].peer == it.body.peer)
                    hit = i;
            end
            if (hit >= 0) begin
                r.status    = ST_UPDATED;
                r.slot      = hit[2:0];
                peers[hit]  = it.body;
            end else if (peer_count >= TABLE_ENTRIES) begin
                r.status = ST_FULL;
            end else begin
                r.status          = ST_INSERTED;
                r.slot            = peer_count[2:0];
                peers[peer_count] = it.body;
                peer_count++;
            end
        end
        r.count = peer_count[3:0];
        return r;
    endfunction

    function automatic rx_item_t make_beacon(input logic ok, input logic [7:0] len,
                                             input logic [7:0] magic, input logic [15:0] peer,
                                             input int lat, input int lon, input int alt,
                                             input logic [7:0] sats, input logic [31:0] now_ms);
        rx_item_t it;
        it.rx_ok       = ok;
        it.body.len    = len;
        it.body.magic  = magic;
        it.body.peer   = peer;
        it.body.lat    = lat[27:0];
        it.body.lon    = lon[28:0];
        it.body.alt    = alt[15:0];
        it.body.sats   = sats;
        it.body.now_ms = now_ms;
        return it;
    endfunction

    // mostly well-formed beacons from known peers, plus echoes, strangers and noise
    function automatic rx_item_t random_beacon();
        rx_item_t    it;
        int          roll;
        logic [15:0] peer;
        logic [7:0]  len;
        logic [7:0]  magic;
        roll  = $urandom_range(0, 99);
        len   = 8'($urandom_range(BEACON_BYTES, 255));
        magic = BEACON_MARK;
        peer  = 16'($urandom_range(0, 65535));
        if (roll < 12) begin
            if ($urandom_range(0, 1))
                len = 8'($urandom_range(0, BEACON_BYTES - 1));
            else
                magic = BEACON_MARK ^ 8'($urandom_range(1, 255));
        end else if (roll < 20) begin
            peer = node_id;
        end else if (roll >= 40 && peer_count > 0) begin
            peer = peers[$urandom_range(0, peer_count - 1)].peer;
        end
        it = make_beacon(roll >= 5, len, magic, peer,
                         int'($urandom_range(0, 180000000)) - 90000000,
                         int'($urandom_range(0, 360000000)) - 180000000,
                         int'($urandom_range(0, 65535)) - 32768,
                         8'($urandom_range(0, 255)), $urandom());
        return it;
    endfunction

    task automatic settle();
        do @(posedge i_clk);
        while (beacon_q.size() != 0 || s_axis_tvalid || reply_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_own_id(input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        node_id      = value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        fault_count++;
        if (fault_count <= 10)
            $display("tb_top: %s mismatch, expected %0d, got %0d", what, want, got);
    endtask

    // sender: next item once the current one is taken, with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (tx_gap > 0) begin
                tx_gap        <= tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (beacon_q.size() > 0) begin
                rx_item_t it;
                it = beacon_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= it.rx_ok;
                s_axis_tdata  <= {7'b0, it.body};
                if (!calm && $urandom_range(0, 3) == 0)
                    tx_gap <= $urandom_range(1, 17);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stall bursts and one long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_arm && !hold_spent) begin
            hold_spent    <= 1'b1;
            hold_left     <= LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall      <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            rx_stall      <= $urandom_range(1, 17) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // accepted beacons feed the predictor, accepted results are checked
    always @(posedge i_clk) begin
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken)
            reply_q.push_back(predict_reply({s_axis_tuser, s_axis_tdata[144:0]}));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (reply_q.size() == 0) begin
                note_mismatch("unexpected result, status", -1, int'(m_axis_tuser));
            end else begin
                reply_t want;
                want = reply_q.pop_front();
                if (m_axis_tuser != want.status)
                    note_mismatch("status", int'(want.status), int'(m_axis_tuser));
                if (m_axis_tdata[2:0] != want.slot)
                    note_mismatch("slot", int'(want.slot), int'(m_axis_tdata[2:0]));
                if (m_axis_tdata[6:3] != want.count)
                    note_mismatch("peer count", int'(want.count), int'(m_axis_tdata[6:3]));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: rejects, echo, fill, updates, full table
        write_own_id(16'h0000);
        beacon_q.push_back(make_beacon(1'b0, 8'd255, BEACON_MARK, 16'h1234,
                                       90000000, -180000000, 32767, 8'hFF, 32'hFFFF_FFFF));
        beacon_q.push_back(make_beacon(1'b0, 8'd0, 8'h00, 16'h0000, 0, 0, 0, 8'h00, 32'h0));
        beacon_q.push_back(make_beacon(1'b1, 8'd13, BEACON_MARK, 16'h0005, 1, 1, 1, 8'd3, 32'd7));
        beacon_q.push_back(make_beacon(1'b1, 8'd0, BEACON_MARK, 16'h0005, 1, 1, 1, 8'd3, 32'd7));
        beacon_q.push_back(make_beacon(1'b1, 8'd14, 8'hB6, 16'h0005, 1, 1, 1, 8'd3, 32'd7));
        beacon_q.push_back(make_beacon(1'b1, 8'd255, 8'h00, 16'h0005, 1, 1, 1, 8'd3, 32'd7));
        beacon_q.push_back(make_beacon(1'b1, 8'd14, BEACON_MARK, 16'h0000, 2, 2, 2, 8'd4, 32'd9));
        beacon_q.push_back(make_beacon(1'b1, 8'd14, BEACON_MARK, 16'hFFFF,
                                       90000000, -180000000, -32768, 8'hFF, 32'hFFFF_FFFF));
        beacon_q.push_back(make_beacon(1'b1, 8'd255, BEACON_MARK, 16'hFFFF,
                                       -90000000, 180000000, 32767, 8'h00, 32'h0));
        beacon_q.push_back(make_beacon(1'b1, 8'd20, BEACON_MARK, 16'h0001, 10, 20, 30, 8'd5, 32'd100));
        beacon_q.push_back(make_beacon(1'b1, 8'd20, BEACON_MARK, 16'h8000, 11, 21, 31, 8'd6, 32'd101));
        beacon_q.push_back(make_beacon(1'b1, 8'd20, BEACON_MARK, 16'h00FF, 12, 22, 32, 8'd7, 32'd102));
        beacon_q.push_back(make_beacon(1'b1, 8'd20, BEACON_MARK, 16'h0001, 13, 23, 33, 8'd8, 32'd103));
        beacon_q.push_back(make_beacon(1'b1, 8'd20, BEACON_MARK, 16'h7F00, 14, 24, 34, 8'd9, 32'd104));
        beacon_q.push_back(make_beacon(1'b1, 8'd20, BEACON_MARK, 16'h1234, 15, 25, 35, 8'd9, 32'd105));
        beacon_q.push_back(make_beacon(1'b1, 8'd20, BEACON_MARK, 16'hA5C3, 16, 26, 36, 8'd9, 32'd106));
        beacon_q.push_back(make_beacon(1'b1, 8'd20, BEACON_MARK, 16'h5A3C, 17, 27, 37, 8'd9, 32'd107));
        beacon_q.push_back(make_beacon(1'b1, 8'd20, BEACON_MARK, 16'h0002, 18, 28, 38, 8'd9, 32'd108));
        beacon_q.push_back(make_beacon(1'b1, 8'd20, BEACON_MARK, 16'h5A3C, -5, -6, -7, 8'd1, 32'd109));
        beacon_q.push_back(make_beacon(1'b1, 8'd20, BEACON_MARK, 16'h8000, -8, -9, -1, 8'd2, 32'd110));
        beacon_q.push_back(make_beacon(1'b0, 8'd20, BEACON_MARK, 16'h4444, 0, 0, 0, 8'd0, 32'd111));
        settle();

        // own id at the top of its range and equal to a stored peer, then an unknown peer
        write_own_id(16'hFFFF);
        beacon_q.push_back(make_beacon(1'b1, 8'd14, BEACON_MARK, 16'hFFFF, 3, 3, 3, 8'd3, 32'd3));
        beacon_q.push_back(make_beacon(1'b1, 8'd14, BEACON_MARK, 16'h0000, 4, 4, 4, 8'd4, 32'd4));
        hold_arm = 1'b1;
        repeat (160) beacon_q.push_back(random_beacon());
        settle();

        write_own_id(16'($urandom_range(1, 65534)));
        repeat (160) beacon_q.push_back(random_beacon());
        settle();

        write_own_id(peers[3].peer);
        repeat (140) beacon_q.push_back(random_beacon());
        settle();

        // closing stretch without random gaps or stalls
        calm = 1'b1;
        repeat (40) beacon_q.push_back(random_beacon());
        settle();

        if (fault_count == 0 && reply_q.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
